>>> hw/rtl/agab_pkg.sv
// ----------------------------------------------------------------------------
// agab_pkg
// Shared types and helpers for the ARGB32 alpha blender with global alpha.
// ----------------------------------------------------------------------------
package agab_pkg;

	localparam int unsigned ChanW     = 8;
	localparam int unsigned PixW      = 32;
	localparam int unsigned ProdW     = 16;
	localparam logic [ChanW-1:0] ChMax   = 8'hFF;
	localparam logic [ProdW-1:0] ChRound = 16'd127;
	localparam int unsigned AlphaLsb  = 24;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic [ProdW-1:0] prod_t;

	typedef struct packed {
		logic [PixW-1:0] src_pixel;
		logic [PixW-1:0] dst_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [PixW-1:0] out_pixel;
		logic            write_needed;
	} pix_out_t;

	// Rounded-down division by 255, exact for every value up to 255*255 + 127.
	function automatic chan_t div255(input prod_t x);
		logic [ProdW:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[ProdW-1:ChanW]};
		return t[ProdW-1:ChanW];
	endfunction

endpackage

>>> hw/rtl/argb_alpha_blend_global_alpha_unit.sv
// ----------------------------------------------------------------------------
// argb_alpha_blend_global_alpha_unit
// Source-over blend of ARGB32 pixel pairs with a global opacity register.
// ----------------------------------------------------------------------------
// Each request on the item channel carries a source and a destination pixel.
// The result channel returns the blended pixel and a write flag that is low
// when the effective alpha is zero and the destination is left unchanged.
// The cfg channel writes the 8-bit global alpha; it is always ready. It must be
// written only while the pipeline is empty; the block itself does not enforce this.
// Four register stages: scaled-alpha product, effective alpha, per-channel
// weighted sums, and the output register, which a request passes in order.
// One request is taken every cycle unless item_stall is high; the rate is
// set by the four-stage pipeline, one pixel pair per stage.
// When the receiver stalls, the output register holds and the stages behind
// it close up their bubbles; item_stall rises only once every stage is full.
// Reset empties the pipeline and sets the global alpha to 255.
// ----------------------------------------------------------------------------
module argb_alpha_blend_global_alpha_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  agab_pkg::pix_in_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output agab_pkg::pix_out_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  agab_pkg::chan_t    cfg_data
);
	import agab_pkg::*;

	chan_t ga_q;

	logic v1, v2, v3, v4;
	logic en1, en2, en3, en4;

	pix_in_t pix_s1, pix_s2, pix_s3;
	prod_t   prod_s1;
	logic    ga_full_s1;
	chan_t   a_s2, a_s3;
	chan_t   a_eff;
	chan_t   q_r, q_g, q_b, q_a;
	logic [ChanW:0] oa_sum;
	chan_t   oa;
	pix_out_t res_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ga_q <= ChMax;
		end else if (cfg_valid && cfg_ready) begin
			ga_q <= cfg_data;
		end
	end

	assign en4 = !v4 || !result_stall;
	assign en3 = !v3 || en4;
	assign en2 = !v2 || en3;
	assign en1 = !v1 || en2;
	assign item_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
		end else begin
			if (en1) v1 <= item_valid;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pix_s1     <= item;
			prod_s1    <= prod_t'(item.src_pixel[PixW-1:AlphaLsb]) * prod_t'(ga_q) + ChRound;
			ga_full_s1 <= (ga_q == ChMax);
		end
	end

	assign a_eff = ga_full_s1 ? pix_s1.src_pixel[PixW-1:AlphaLsb] : div255(prod_s1);

	always_ff @(posedge clk) begin
		if (en2) begin
			pix_s2 <= pix_s1;
			a_s2   <= a_eff;
		end
		if (en3) begin
			pix_s3 <= pix_s2;
			a_s3   <= a_s2;
		end
	end

	agab_lane u_lane_r (
		.clk(clk), .en(en3),
		.s(pix_s2.src_pixel[23:16]), .d(pix_s2.dst_pixel[23:16]), .a(a_s2), .q(q_r)
	);
	agab_lane u_lane_g (
		.clk(clk), .en(en3),
		.s(pix_s2.src_pixel[15:8]), .d(pix_s2.dst_pixel[15:8]), .a(a_s2), .q(q_g)
	);
	agab_lane u_lane_b (
		.clk(clk), .en(en3),
		.s(pix_s2.src_pixel[7:0]), .d(pix_s2.dst_pixel[7:0]), .a(a_s2), .q(q_b)
	);
	agab_lane u_lane_a (
		.clk(clk), .en(en3),
		.s('0), .d(pix_s2.dst_pixel[PixW-1:AlphaLsb]), .a(a_s2), .q(q_a)
	);

	assign oa_sum = {1'b0, a_s3} + {1'b0, q_a};
	assign oa     = oa_sum[ChanW] ? ChMax : oa_sum[ChanW-1:0];

	always_comb begin
		if (a_s3 == '0) begin
			res_d.out_pixel    = pix_s3.dst_pixel;
			res_d.write_needed = 1'b0;
		end else if (a_s3 == ChMax) begin
			res_d.out_pixel    = pix_s3.src_pixel;
			res_d.write_needed = 1'b1;
		end else begin
			res_d.out_pixel    = {oa, q_r, q_g, q_b};
			res_d.write_needed = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			result <= res_d;
		end
	end

	assign result_valid = v4;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v1 && v2 && v3 && v4 && result_stall))
		else $error("item_stall raised while the pipeline has room");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v3 && en4) |=> v4)
		else $error("request lost between stage three and the output register");

	a_zero_alpha_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(v3 && en4 && a_s3 == '0) |=> !result.write_needed)
		else $error("write flag set for zero effective alpha");

endmodule

>>> hw/rtl/agab_lane.sv
// ----------------------------------------------------------------------------
// agab_lane
// One 8-bit channel of the blend: registered weighted sum, then divide by 255.
// ----------------------------------------------------------------------------
module agab_lane (
	input  logic           clk,
	input  logic           en,
	input  agab_pkg::chan_t s,
	input  agab_pkg::chan_t d,
	input  agab_pkg::chan_t a,
	output agab_pkg::chan_t q
);
	import agab_pkg::*;

	prod_t sum_s3;
	chan_t inv_a;

	assign inv_a = ChMax - a;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= prod_t'(s) * prod_t'(a) + prod_t'(d) * prod_t'(inv_a) + ChRound;
		end
	end

	assign q = div255(sum_s3);

endmodule

>>> test/tb_argb_alpha_blend_global_alpha_unit.sv
// ----------------------------------------------------------------------------
// tb_argb_alpha_blend_global_alpha_unit
// Self-checking bench for the ARGB32 source-over blender with global alpha.
// ----------------------------------------------------------------------------
// A queue of pixel pairs feeds a clocked driver with random gaps, and a
// clocked monitor with random stalls compares every blended pixel and write
// flag against a predictor computed when the request is accepted. The run
// covers directed corner pixels, many global alpha settings including both
// extremes, and a long receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_argb_alpha_blend_global_alpha_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import agab_pkg::*;

	localparam int unsigned CH_FULL     = 255;
	localparam int unsigned CH_HALF     = 127;
	localparam int unsigned PHASE_ITEMS = 200;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned MAX_PRINTS  = 20;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_stall;
	pix_in_t  item         = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	pix_out_t result;
	logic     cfg_valid    = 1'b0;
	logic     cfg_ready;
	chan_t    cfg_data     = '0;

	pix_in_t  pixel_q[$];
	pix_out_t blend_expect_q[$];
	chan_t    ga_model     = 8'hFF;
	bit       tx_burst     = 1'b0;
	bit       rx_burst     = 1'b0;
	logic     rx_hold      = 1'b0;
	int       send_gap     = 0;
	int       stall_left   = 0;
	int       n_pushed     = 0;
	int       n_results    = 0;
	int       n_mismatch   = 0;
	int       n_settings   = 0;
	int       quiet_cycles = 0;

	argb_alpha_blend_global_alpha_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic pix_out_t blend_pixel(input pix_in_t p, input chan_t ga);
		int unsigned a;
		int unsigned da;
		int unsigned oa;
		int unsigned sc;
		int unsigned dc;
		int          k;
		pix_out_t    r;
		a = p.src_pixel[31:24];
		if (ga != CH_FULL)
			a = (a * ga + CH_HALF) / CH_FULL;
		r.write_needed = 1'b1;
		if (a == 0) begin
			r.out_pixel    = p.dst_pixel;
			r.write_needed = 1'b0;
		end else if (a == CH_FULL) begin
			r.out_pixel = p.src_pixel;
		end else begin
			da = p.dst_pixel[31:24];
			oa = a + (da * (CH_FULL - a) + CH_HALF) / CH_FULL;
			if (oa > CH_FULL)
				oa = CH_FULL;
			r.out_pixel[31:24] = oa[7:0];
			for (k = 0; k < 3; k++) begin
				sc = p.src_pixel[8*k +: 8];
				dc = p.dst_pixel[8*k +: 8];
				r.out_pixel[8*k +: 8] = 8'((sc * a + dc * (CH_FULL - a) + CH_HALF) / CH_FULL);
			end
		end
		return r;
	endfunction

	function automatic pix_in_t random_pair();
		pix_in_t p;
		p.src_pixel = $urandom;
		p.dst_pixel = $urandom;
		case ($urandom_range(0, 5))
			0: p.src_pixel[31:24] = 8'h00;
			1: p.src_pixel[31:24] = 8'hFF;
			2: p.dst_pixel[31:24] = 8'hFF;
			default: ;
		endcase
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (n_mismatch < MAX_PRINTS)
			$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		n_mismatch++;
	endtask

	task automatic send_pixels(input logic [31:0] src, input logic [31:0] dst);
		pixel_q.push_back('{src_pixel: src, dst_pixel: dst});
		n_pushed++;
	endtask

	task automatic wait_drained();
		while (n_results != n_pushed)
			@(posedge clk);
	endtask

	task automatic write_global_alpha(input chan_t v);
		wait_drained();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		ga_model = v;
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				blend_expect_q.push_back(blend_pixel(item, ga_model));
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					item_valid <= 1'b0;
					send_gap--;
				end else if (pixel_q.size() != 0) begin
					item       <= pixel_q.pop_front();
					item_valid <= 1'b1;
					send_gap = tx_burst ? 0 : $urandom_range(0, 8);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		pix_out_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				n_results++;
				if (blend_expect_q.size() == 0) begin
					report_mismatch("unexpected result, out_pixel", result.out_pixel, '0);
				end else begin
					want = blend_expect_q.pop_front();
					if (result.out_pixel !== want.out_pixel)
						report_mismatch("out_pixel", result.out_pixel, want.out_pixel);
					if (result.write_needed !== want.write_needed)
						report_mismatch("write_needed", 32'(result.write_needed),
							32'(want.write_needed));
				end
				stall_left = rx_burst ? 0 : $urandom_range(0, 8);
			end
			if (rx_hold) begin
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		chan_t ga_plan[10];
		int    ph;
		int    i;
		ga_plan = '{8'd0, 8'hFF, 8'd1, 8'd254, 8'd128, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0};
		for (ph = 6; ph < 10; ph++)
			ga_plan[ph] = chan_t'($urandom_range(0, 255));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset value of the global alpha applies until the first write.
		@(negedge clk);
		send_pixels(32'h00FFFFFF, 32'h12345678);
		send_pixels(32'h00000000, 32'hFFFFFFFF);
		send_pixels(32'hFFFFFFFF, 32'h00000000);
		send_pixels(32'hFF123456, 32'hABCDEF01);
		send_pixels(32'h80FFFFFF, 32'h00000000);
		send_pixels(32'h80000000, 32'hFFFFFFFF);
		send_pixels(32'h01FFFFFF, 32'hFF000000);
		send_pixels(32'hFEFFFFFF, 32'hFFFFFFFF);
		send_pixels(32'hFE000000, 32'hFF808080);
		send_pixels(32'h7F804020, 32'h40C0E0F0);

		write_global_alpha(8'd0);
		@(negedge clk);
		send_pixels(32'hFFFFFFFF, 32'h5A5A5A5A);
		send_pixels(32'h80112233, 32'hA5A5A5A5);

		write_global_alpha(8'd1);
		@(negedge clk);
		send_pixels(32'hFFFFFFFF, 32'h00000000);
		send_pixels(32'h7FFFFFFF, 32'h11223344);
		send_pixels(32'h80FFFFFF, 32'h00000000);

		write_global_alpha(8'd254);
		@(negedge clk);
		send_pixels(32'hFF00FF00, 32'hFFFF00FF);
		send_pixels(32'h01FFFFFF, 32'h00000000);
		send_pixels(32'hFFFFFFFF, 32'hFFFFFFFF);

		for (ph = 0; ph < 10; ph++) begin
			write_global_alpha(ga_plan[ph]);
			@(negedge clk);
			tx_burst = (ph % 4 == 0);
			rx_burst = (ph % 4 == 0) || (ph % 4 == 3);
			for (i = 0; i < PHASE_ITEMS; i++)
				pixel_q.push_back(random_pair());
			n_pushed += PHASE_ITEMS;
		end

		// Receiver holds off while the sender keeps offering requests.
		write_global_alpha(8'd200);
		@(negedge clk);
		tx_burst = 1'b1;
		rx_burst = 1'b1;
		for (i = 0; i < 64; i++)
			pixel_q.push_back(random_pair());
		n_pushed += 64;
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (blend_expect_q.size() != 0)
			report_mismatch("pixels still pending at end, count", blend_expect_q.size(), 0);

		$display("Blended %0d pixel pairs over %0d global alpha writes, random gaps and stalls,",
			n_results, n_settings);
		$display("and a %0d-cycle receiver hold-off; %0d mismatches.", HOLD_CYCLES, n_mismatch);
		if (n_mismatch == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
